>>> rtl/core/sorted_insert_priority_queue_top_defines.svh
// assertion macros shared by the priority queue rtl
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/spq_pkg.sv
// shared types and constants of the sorted priority queue
package spq_pkg;

	localparam int CAPACITY = 8;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [7:0]  pri;
		logic [15:0] id;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_PUT,
		S_RESP
	} state_t;

endpackage

>>> rtl/core/spq_mem.sv
// entry storage: one write port, one registered read port
module spq_mem (
	input  logic              clk,
	input  spq_pkg::mem_req_t req,
	output spq_pkg::entry_t   rd_data
);
	import spq_pkg::*;

	entry_t mem [CAPACITY];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[req.raddr];
	end

endmodule

>>> rtl/core/spq_cmp.sv
// service order compare: true when a is served strictly before b
module spq_cmp (
	input  spq_pkg::entry_t a,
	input  spq_pkg::entry_t b,
	output logic            a_first
);
	import spq_pkg::*;

	// priority first, id breaks ties
	always_comb begin
		if (a.pri != b.pri) begin
			a_first = (a.pri < b.pri);
		end else begin
			a_first = (a.id < b.id);
		end
	end

endmodule

>>> rtl/core/sorted_insert_priority_queue_top.sv
// Sorted priority queue, stored entries visited one at a time by a shared compare.
// Insert: walks entries from the tail, shifting each up until the new one goes behind it, else places it at the head.
// Remove: reads each held entry from the head, keeps the head and shifts the rest down, then gives the result.
// Full or empty cases give their result in the cycle after the transfer.
// One item at a time; the next can be taken from the cycle after the result transfer.
// Reset (arst_n low, asynchronous) empties the queue; the storage is not cleared.
module sorted_insert_priority_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [15:0] item_id,
	input  logic [7:0]  item_priority,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] served_id,
	output logic [7:0]  served_priority,
	output logic [3:0]  occupancy
);
	import spq_pkg::*;
	`include "sorted_insert_priority_queue_top_defines.svh"

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic             op_q;
	entry_t           new_q;
	entry_t           served_q;
	logic [1:0]       status_q;

	entry_t   rd_data;
	mem_req_t mem_req;
	logic     new_first;
	logic     full;
	logic     empty;
	logic     last;
	logic     in_xfer;

	assign full    = (count_q == CNT_W'(CAPACITY));
	assign empty   = (count_q == '0);
	assign last    = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign in_xfer = in_valid && in_ready;

	spq_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	spq_cmp u_cmp (
		.a       (new_q),
		.b       (rd_data),
		.a_first (new_first)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation == OP_INSERT) begin
						if (full) begin
							state_d = S_RESP;
						end else if (empty) begin
							state_d = S_PUT;
						end else begin
							state_d = S_READ;
						end
					end else begin
						state_d = empty ? S_RESP : S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (op_q == OP_INSERT) begin
					if (new_first) begin
						state_d = (idx_q == '0) ? S_PUT : S_READ;
					end else begin
						state_d = S_RESP;
					end
				end else begin
					state_d = last ? S_RESP : S_READ;
				end
			end
			S_PUT: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// handshake and storage port controls
	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = '0;
		mem_req.wdata = new_q;
		mem_req.raddr = idx_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_CMP: begin
				if (op_q == OP_INSERT) begin
					// shift the visited entry up, or drop the new one in behind it
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q + IDX_W'(1);
					mem_req.wdata = new_first ? rd_data : new_q;
				end else if (idx_q != '0) begin
					// shift toward the head
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q - IDX_W'(1);
					mem_req.wdata = rd_data;
				end
			end
			S_PUT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = '0;
				mem_req.wdata = new_q;
			end
			S_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (operation == OP_INSERT) begin
							idx_q <= IDX_W'(count_q - CNT_W'(1));
						end else begin
							idx_q <= '0;
						end
					end
				end
				S_CMP: begin
					if (op_q == OP_INSERT) begin
						if (new_first) begin
							if (idx_q != '0) begin
								idx_q <= idx_q - IDX_W'(1);
							end
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end else if (last) begin
						count_q <= count_q - CNT_W'(1);
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_PUT: begin
					count_q <= count_q + CNT_W'(1);
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q     <= operation;
			new_q    <= '{pri: item_priority, id: item_id};
			served_q <= '0;
			if (operation == OP_INSERT) begin
				status_q <= full ? ST_FULL : ST_DONE;
			end else begin
				status_q <= empty ? ST_EMPTY : ST_DONE;
			end
		end else if (state_q == S_CMP && op_q == OP_REMOVE && idx_q == '0) begin
			served_q <= rd_data;
		end
	end

	assign status          = status_q;
	assign served_id       = served_q.id;
	assign served_priority = served_q.pri;
	assign occupancy       = 4'(count_q);

	// checks
	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY),
		"occupancy above capacity")
	`SPQ_ASSERT_NOW(a_no_overlap, in_ready, !out_valid,
		"input taken while a result is pending")
	`SPQ_ASSERT_NOW(a_write_busy, mem_req.we, state_q == S_CMP || state_q == S_PUT,
		"storage written outside a walk")
	`SPQ_ASSERT_NEXT(a_full_reject, in_xfer && operation == OP_INSERT && full,
		out_valid && status_q == ST_FULL && $stable(count_q),
		"insert on full queue not rejected at once")
	`SPQ_ASSERT_NEXT(a_empty_remove, in_xfer && operation == OP_REMOVE && empty,
		out_valid && status_q == ST_EMPTY && served_q == '0,
		"remove on empty queue not reported at once")

endmodule
